FILE: design/swin_pkg.sv
`timescale 1ns / 1ps
package swin_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int COUNT_W     = 4;
  localparam int MEAN_W      = 24;
  localparam int FRAC_W      = 8;
  localparam int WINDOW_DEF  = 8;
  localparam int QUEUE_DEPTH = 2;

endpackage

FILE: design/swin_if.sv
`timescale 1ns / 1ps
interface swin_in_if import swin_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swin_out_if import swin_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic        [COUNT_W-1:0]  held_count;
  logic signed [SAMPLE_W-1:0] window_min;
  logic signed [SAMPLE_W-1:0] window_max;
  logic signed [MEAN_W-1:0]   window_mean;

  modport source (output valid, output held_count, output window_min, output window_max,
                  output window_mean, input ready);
  modport sink   (input valid, input held_count, input window_min, input window_max,
                  input window_mean, output ready);
endinterface

FILE: design/swin_queue.sv
`timescale 1ns / 1ps
module swin_queue import swin_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         full,
  output logic         not_empty
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]  entry_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] level_r, level_nxt;

  assign full      = (level_r == CW'(QUEUE_DEPTH));
  assign not_empty = (level_r != '0);
  assign dout      = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      level_nxt = level_r + 1'b1;
    end else if (pop && !push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= din;
    end
  end

endmodule

FILE: design/swin_front.sv
`timescale 1ns / 1ps
module swin_front import swin_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF,
  parameter int AW     = $clog2(WINDOW),
  parameter int CNTW   = $clog2(WINDOW + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  swin_in_if.sink                    in_ch,
  input  logic                       q_full,
  output logic                       q_push,
  output logic signed [SAMPLE_W-1:0] job_sample,
  output logic        [AW-1:0]       job_addr,
  output logic        [CNTW-1:0]     job_cnt,
  output logic                       job_replace
);

  logic [CNTW-1:0] fill_r, fill_nxt;
  logic [AW-1:0]   ptr_r, ptr_nxt;
  logic            filling;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign filling     = (fill_r < CNTW'(WINDOW));
  assign job_sample  = in_ch.sample;
  assign job_replace = !filling;

  // While filling, append at the fill count; once full, overwrite the oldest entry
  always_comb begin
    fill_nxt = fill_r;
    ptr_nxt  = ptr_r;
    if (filling) begin
      job_addr = fill_r[AW-1:0];
      job_cnt  = fill_r + 1'b1;
      if (q_push) begin
        fill_nxt = fill_r + 1'b1;
      end
    end else begin
      job_addr = ptr_r;
      job_cnt  = CNTW'(WINDOW);
      if (q_push) begin
        ptr_nxt = (ptr_r == AW'(WINDOW - 1)) ? '0 : ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      ptr_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      ptr_r  <= ptr_nxt;
    end
  end

endmodule

FILE: design/swin_div.sv
`timescale 1ns / 1ps
module swin_div import swin_pkg::*; #(
  parameter int SUMW = 20,
  parameter int CNTW = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [SUMW-1:0]   sum,
  input  logic        [CNTW-1:0]   den,
  output logic                     done,
  output logic signed [MEAN_W-1:0] mean
);

  localparam int NUMW = SUMW + FRAC_W;
  localparam int STW  = $clog2(NUMW + 1);

  logic [NUMW-1:0] num_r;
  logic [CNTW-1:0] rem_r;
  logic [CNTW-1:0] den_r;
  logic [STW-1:0]  step_r;
  logic            neg_r;
  logic            busy_r;
  logic            done_r;
  logic [SUMW-1:0] mag;
  logic [CNTW:0]   rem_sh;
  logic [CNTW:0]   rem_sub;
  logic            q_bit;
  logic [NUMW-1:0] quot;

  assign mag     = sum[SUMW-1] ? SUMW'(-sum) : SUMW'(sum);
  assign rem_sh  = {rem_r, num_r[NUMW-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign q_bit   = (rem_sh >= {1'b0, den_r});
  assign quot    = neg_r ? (~num_r + 1'b1) : num_r;
  assign mean    = quot[MEAN_W-1:0];
  assign done    = done_r;

  // Restoring division of |sum| * 256: one quotient bit per cycle, sign applied at the end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && step_r == STW'(1)) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r  <= {mag, {FRAC_W{1'b0}}};
      rem_r  <= '0;
      den_r  <= den;
      neg_r  <= sum[SUMW-1];
      step_r <= STW'(NUMW);
    end else if (busy_r) begin
      num_r  <= {num_r[NUMW-2:0], q_bit};
      rem_r  <= q_bit ? rem_sub[CNTW-1:0] : rem_sh[CNTW-1:0];
      step_r <= step_r - 1'b1;
    end
  end

endmodule

FILE: design/swin_back.sv
`timescale 1ns / 1ps
module swin_back import swin_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF,
  parameter int AW     = $clog2(WINDOW),
  parameter int CNTW   = $clog2(WINDOW + 1),
  parameter int SUMW   = SAMPLE_W + CNTW
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  logic signed [SAMPLE_W-1:0] q_sample,
  input  logic        [AW-1:0]       q_addr,
  input  logic        [CNTW-1:0]     q_cnt,
  input  logic                       q_replace,
  output logic                       q_pop,
  swin_out_if.source                 out_ch
);

  typedef enum logic [1:0] {S_IDLE, S_UPD, S_SCAN, S_OUT} state_t;

  state_t                     state_r;
  logic signed [SAMPLE_W-1:0] mem_r [WINDOW];
  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic        [AW-1:0]       rd_addr;
  logic                       mem_we;

  logic signed [SAMPLE_W-1:0] sample_r;
  logic        [AW-1:0]       addr_r;
  logic        [CNTW-1:0]     cnt_r;
  logic                       replace_r;
  logic signed [SUMW-1:0]     sum_r;
  logic signed [SUMW-1:0]     sum_nxt;

  logic        [CNTW-1:0]     rd_idx_r;
  logic                       cmp_vld_r;
  logic                       cmp_first_r;
  logic                       start_r;
  logic signed [SAMPLE_W-1:0] min_r;
  logic signed [SAMPLE_W-1:0] max_r;
  logic                       scan_done;

  logic                       div_done;
  logic signed [MEAN_W-1:0]   div_mean;

  logic                       out_valid_r;
  logic        [COUNT_W-1:0]  held_count_r;
  logic signed [SAMPLE_W-1:0] window_min_r;
  logic signed [SAMPLE_W-1:0] window_max_r;
  logic signed [MEAN_W-1:0]   window_mean_r;
  logic                       out_free;

  swin_div #(
    .SUMW (SUMW),
    .CNTW (CNTW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .sum   (sum_r),
    .den   (cnt_r),
    .done  (div_done),
    .mean  (div_mean)
  );

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign rd_addr   = (state_r == S_IDLE) ? q_addr : rd_idx_r[AW-1:0];
  assign mem_we    = (state_r == S_UPD);
  assign scan_done = (rd_idx_r == cnt_r) && !cmp_vld_r && !start_r;
  assign out_free  = !out_valid_r || out_ch.ready;

  // rd_data_r holds the entry being overwritten when in S_UPD
  assign sum_nxt = sum_r - (replace_r ? SUMW'(rd_data_r) : '0) + SUMW'(sample_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[addr_r] <= sample_r;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      start_r     <= 1'b0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            sample_r  <= q_sample;
            addr_r    <= q_addr;
            cnt_r     <= q_cnt;
            replace_r <= q_replace;
            state_r   <= S_UPD;
          end
        end
        S_UPD: begin
          sum_r       <= sum_nxt;
          start_r     <= 1'b1;
          rd_idx_r    <= '0;
          cmp_vld_r   <= 1'b0;
          cmp_first_r <= 1'b1;
          state_r     <= S_SCAN;
        end
        S_SCAN: begin
          start_r <= 1'b0;
          // advance the read address one entry a cycle; data is compared in the following cycle
          if (rd_idx_r < cnt_r) begin
            rd_idx_r  <= rd_idx_r + 1'b1;
            cmp_vld_r <= 1'b1;
          end else begin
            cmp_vld_r <= 1'b0;
          end
          if (cmp_vld_r) begin
            cmp_first_r <= 1'b0;
            if (cmp_first_r || rd_data_r < min_r) begin
              min_r <= rd_data_r;
            end
            if (cmp_first_r || rd_data_r > max_r) begin
              max_r <= rd_data_r;
            end
          end
          if (scan_done && div_done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            held_count_r  <= COUNT_W'(cnt_r);
            window_min_r  <= min_r;
            window_max_r  <= max_r;
            window_mean_r <= div_mean;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.held_count  = held_count_r;
  assign out_ch.window_min  = window_min_r;
  assign out_ch.window_max  = window_max_r;
  assign out_ch.window_mean = window_mean_r;

  a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> (div_done && rd_idx_r == cnt_r))
    else $error("result stage entered before scan and divide finished");

  a_min_not_above_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> (min_r <= max_r))
    else $error("window minimum above maximum");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> (cnt_r != '0 && cnt_r <= CNTW'(WINDOW)))
    else $error("job carries a held count out of range");

  a_upd_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> $past(q_pop))
    else $error("update started without a queue beat");

endmodule

FILE: design/sliding_window_stats.sv
`timescale 1ns / 1ps
// Sliding-window min/max/mean over signed 16-bit samples, one result beat per sample beat.
// Each sample enters a short queue, then the back end writes it into the window memory
// (overwriting the oldest entry once WINDOW samples are held), scans the held entries for
// minimum and maximum at one entry per cycle, and divides sum*256 by the held count with
// a bit-serial divider that runs alongside the scan. The back end takes the next sample
// from the queue only after both scan and divide are done and the result is registered.
// The window memory needs no clearing after reset; entries above the fill count are
// never read. held_count shows the count modulo 16.
module sliding_window_stats import swin_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  swin_in_if.sink    in_ch,
  swin_out_if.source out_ch
);

  localparam int AW   = $clog2(WINDOW);
  localparam int CNTW = $clog2(WINDOW + 1);
  localparam int SUMW = SAMPLE_W + CNTW;
  localparam int JW   = SAMPLE_W + AW + CNTW + 1;

  logic                       q_full;
  logic                       q_push;
  logic                       q_pop;
  logic                       q_valid;
  logic signed [SAMPLE_W-1:0] job_sample;
  logic        [AW-1:0]       job_addr;
  logic        [CNTW-1:0]     job_cnt;
  logic                       job_replace;
  logic        [JW-1:0]       q_din;
  logic        [JW-1:0]       q_dout;
  logic signed [SAMPLE_W-1:0] q_sample;
  logic        [AW-1:0]       q_addr;
  logic        [CNTW-1:0]     q_cnt;
  logic                       q_replace;

  swin_front #(
    .WINDOW (WINDOW),
    .AW     (AW),
    .CNTW   (CNTW)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .q_full      (q_full),
    .q_push      (q_push),
    .job_sample  (job_sample),
    .job_addr    (job_addr),
    .job_cnt     (job_cnt),
    .job_replace (job_replace)
  );

  assign q_din = {job_sample, job_addr, job_cnt, job_replace};

  swin_queue #(
    .W (JW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .din       (q_din),
    .pop       (q_pop),
    .dout      (q_dout),
    .full      (q_full),
    .not_empty (q_valid)
  );

  assign {q_sample, q_addr, q_cnt, q_replace} = q_dout;

  swin_back #(
    .WINDOW (WINDOW),
    .AW     (AW),
    .CNTW   (CNTW),
    .SUMW   (SUMW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_sample  (q_sample),
    .q_addr    (q_addr),
    .q_cnt     (q_cnt),
    .q_replace (q_replace),
    .q_pop     (q_pop),
    .out_ch    (out_ch)
  );

endmodule
